[hdl/can_tlv_command_link_top_macros.svh]
// assertion macros used by the link back end
`ifndef CAN_TLV_COMMAND_LINK_TOP_MACROS_SVH
`define CAN_TLV_COMMAND_LINK_TOP_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define CTCL_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ctcl assertion failed");

// next-cycle implication, checked on clk outside reset
`define CTCL_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ctcl assertion failed");

`endif

[hdl/ctcl_pkg.sv]
// shared types, codes and sizes of the tlv command link
package ctcl_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MOTOR_COUNT = 4;
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  localparam logic [10:0] RX_ID = 11'h446;

  // request codes
  localparam logic [2:0] REQ_ENQ  = 3'd0;
  localparam logic [2:0] REQ_RX   = 3'd1;
  localparam logic [2:0] REQ_SEND = 3'd2;
  localparam logic [2:0] REQ_MQ   = 3'd3;
  localparam logic [2:0] REQ_CQ   = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_TX    = 3'd1;
  localparam logic [2:0] KIND_MOTOR = 3'd2;
  localparam logic [2:0] KIND_CNT   = 3'd3;
  localparam logic [2:0] KIND_DONE  = 3'd4;
  localparam logic [2:0] KIND_LIMIT = 3'd5;

  // received tags
  localparam logic [7:0] TAG_OK    = 8'h40;
  localparam logic [7:0] TAG_FAIL  = 8'h41;
  localparam logic [7:0] TAG_RPM   = 8'h42;
  localparam logic [7:0] TAG_ENC   = 8'h43;
  localparam logic [7:0] TAG_DONE  = 8'h44;
  localparam logic [7:0] TAG_LIMIT = 8'h45;

  // segment parts
  localparam logic [1:0] PART_WHOLE  = 2'd0;
  localparam logic [1:0] PART_FIRST  = 2'd1;
  localparam logic [1:0] PART_SECOND = 2'd2;

  // configuration register indexes
  localparam logic [3:0] CFG_LINK_EN  = 4'd0;
  localparam logic [3:0] CFG_TX_ID    = 4'd1;
  localparam logic [3:0] CFG_DONE_EN  = 4'd2;
  localparam logic [3:0] CFG_LIMIT_EN = 4'd3;

  typedef enum logic [2:0] {
    OP_NOP, OP_ENQ, OP_RX, OP_SEND, OP_MQ, OP_CQ
  } op_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [10:0] head_code;
    logic [3:0]  count;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;
    logic [7:0]  byte_8;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] frame_len;
    logic [7:0] out_0;
    logic [7:0] out_1;
    logic [7:0] out_2;
    logic [7:0] out_3;
    logic [7:0] out_4;
    logic [7:0] out_5;
    logic [7:0] out_6;
    logic [7:0] out_7;
    logic       queue_full;
    logic       awaiting_reply;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    op_t      op;
    logic     enq_ok;
    logic     enq_two;
    logic     rx_ok;
    in_item_t item;
  } cmd_t;

  typedef struct packed {
    logic       link_enable;
    logic [10:0] tx_frame_id;
    logic       done_event_enable;
    logic       limit_event_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      tag;
    logic [3:0]      len;
    logic [1:0]      part;
    logic [5:0][7:0] data;
  } seg_t;

endpackage

[hdl/ctcl_front.sv]
// front end: decodes request type and checks frame consistency
module ctcl_front (
  input  ctcl_pkg::in_item_t item,
  output ctcl_pkg::cmd_t     cmd
);

  logic [7:0] size_ext;
  ctcl_pkg::op_t op;

  // operation decode
  always_comb begin
    unique case (item.req_type)
      ctcl_pkg::REQ_ENQ:  op = ctcl_pkg::OP_ENQ;
      ctcl_pkg::REQ_RX:   op = ctcl_pkg::OP_RX;
      ctcl_pkg::REQ_SEND: op = ctcl_pkg::OP_SEND;
      ctcl_pkg::REQ_MQ:   op = ctcl_pkg::OP_MQ;
      ctcl_pkg::REQ_CQ:   op = ctcl_pkg::OP_CQ;
      default:            op = ctcl_pkg::OP_NOP;
    endcase
  end

  // length and id checks for enqueue and receive
  assign cmd.op      = op;
  assign size_ext    = {4'd0, item.count};
  assign cmd.enq_ok  = (item.count <= 4'd9);
  assign cmd.enq_two = (item.count >= 4'd7);
  assign cmd.rx_ok   = (item.head_code == ctcl_pkg::RX_ID) && (item.count >= 4'd2) &&
                       (item.count <= 4'd8) && ((size_ext - 8'd2) == item.byte_1);
  assign cmd.item    = item;

endmodule

[hdl/ctcl_cmdq.sv]
// two-entry command queue between front and back
module ctcl_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  ctcl_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output ctcl_pkg::cmd_t rd_cmd
);

  ctcl_pkg::cmd_t ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_cmd   = ent_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointer and fill update
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wr_cmd;
    end
  end

endmodule

[hdl/ctcl_back.sv]
// back end: segment queue, tables, counters and result register
module ctcl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ctcl_pkg::cfg_t     cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ctcl_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output ctcl_pkg::out_item_t out_data
);

  localparam logic [ctcl_pkg::QIDX_W-1:0] QLAST = ctcl_pkg::QIDX_W'(ctcl_pkg::QUEUE_DEPTH - 1);

  ctcl_pkg::seg_t seg_r [ctcl_pkg::QUEUE_DEPTH];
  logic [ctcl_pkg::QIDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt, tail1;
  logic [ctcl_pkg::QCNT_W-1:0] used_r, used_nxt;
  logic        wait_r, wait_nxt;
  logic [7:0]  rpm_r [ctcl_pkg::MOTOR_COUNT];
  logic [7:0]  rpm_nxt [ctcl_pkg::MOTOR_COUNT];
  logic [15:0] enc_r [ctcl_pkg::MOTOR_COUNT];
  logic [15:0] enc_nxt [ctcl_pkg::MOTOR_COUNT];
  logic [15:0] cnt_r [4];
  logic [15:0] cnt_nxt [4];
  logic        out_valid_r, out_valid_nxt;
  ctcl_pkg::out_item_t out_data_r, res;
  logic        take;
  logic        wr0_en, wr1_en;
  ctcl_pkg::seg_t seg0, seg1, hs;
  logic [8:0][7:0] vb;
  logic [3:0]  n;
  logic [ctcl_pkg::QCNT_W:0] need_sum;
  logic [ctcl_pkg::MIDX_W-1:0] midx_rx, midx_q;
  logic        mok_rx, mok_q;

  assign take      = cmd_valid && (!out_valid_r || out_ready);
  assign cmd_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign vb = {cmd.item.byte_8, cmd.item.byte_7, cmd.item.byte_6, cmd.item.byte_5,
               cmd.item.byte_4, cmd.item.byte_3, cmd.item.byte_2, cmd.item.byte_1,
               cmd.item.byte_0};
  assign tail1    = (tail_r == QLAST) ? '0 : tail_r + 1'b1;
  assign need_sum = {1'b0, used_r} + (cmd.enq_two ? (ctcl_pkg::QCNT_W+1)'(2) :
                                                    (ctcl_pkg::QCNT_W+1)'(1));
  assign hs       = seg_r[head_r];
  assign midx_rx  = cmd.item.byte_2[ctcl_pkg::MIDX_W-1:0];
  assign midx_q   = cmd.item.byte_0[ctcl_pkg::MIDX_W-1:0];
  assign mok_rx   = (cmd.item.byte_2 < 8'(ctcl_pkg::MOTOR_COUNT));
  assign mok_q    = (cmd.item.byte_0 < 8'(ctcl_pkg::MOTOR_COUNT));

  // segments built from an enqueue item
  always_comb begin
    seg0.tag  = cmd.item.head_code[7:0];
    seg0.len  = cmd.item.count;
    seg0.part = cmd.enq_two ? ctcl_pkg::PART_FIRST : ctcl_pkg::PART_WHOLE;
    seg1.tag  = cmd.item.head_code[7:0];
    seg1.len  = cmd.item.count;
    seg1.part = ctcl_pkg::PART_SECOND;
    for (int i = 0; i < 6; i++) begin
      seg0.data[i] = (cmd.enq_two || (4'(i) < cmd.item.count)) ? vb[i] : 8'd0;
      seg1.data[i] = ((i < 3) && (4'(i + 6) < cmd.item.count)) ? vb[(i + 6) % 9] : 8'd0;
    end
  end

  // payload length of the head segment
  always_comb begin
    case (hs.part)
      ctcl_pkg::PART_FIRST:  n = 4'd6;
      ctcl_pkg::PART_SECOND: n = hs.len - 4'd6;
      default:               n = hs.len;
    endcase
  end

  // execute one command
  always_comb begin
    res      = '0;
    head_nxt = head_r;
    tail_nxt = tail_r;
    used_nxt = used_r;
    wait_nxt = wait_r;
    rpm_nxt  = rpm_r;
    enc_nxt  = enc_r;
    cnt_nxt  = cnt_r;
    wr0_en   = 1'b0;
    wr1_en   = 1'b0;
    if (take) begin
      unique case (cmd.op)
        ctcl_pkg::OP_ENQ: begin
          if (cmd.enq_ok) begin
            if (need_sum > (ctcl_pkg::QCNT_W+1)'(ctcl_pkg::QUEUE_DEPTH)) begin
              res.queue_full = 1'b1;
            end else begin
              wr0_en   = 1'b1;
              wr1_en   = cmd.enq_two;
              tail_nxt = cmd.enq_two ? ((tail1 == QLAST) ? '0 : tail1 + 1'b1) : tail1;
              used_nxt = need_sum[ctcl_pkg::QCNT_W-1:0];
            end
          end
        end
        ctcl_pkg::OP_SEND: begin
          if (cfg.link_enable && (used_r != '0) && !wait_r) begin
            res.kind      = ctcl_pkg::KIND_TX;
            res.frame_len = n + 4'd2;
            res.out_0     = hs.tag;
            res.out_1     = {4'd0, hs.len};
            res.out_2     = hs.data[0];
            res.out_3     = hs.data[1];
            res.out_4     = hs.data[2];
            res.out_5     = hs.data[3];
            res.out_6     = hs.data[4];
            res.out_7     = hs.data[5];
            head_nxt      = (head_r == QLAST) ? '0 : head_r + 1'b1;
            used_nxt      = used_r - 1'b1;
            wait_nxt      = 1'b1;
          end
        end
        ctcl_pkg::OP_RX: begin
          if (cmd.rx_ok) begin
            case (cmd.item.byte_0)
              ctcl_pkg::TAG_OK:   cnt_nxt[0] = cnt_r[0] + 16'd1;
              ctcl_pkg::TAG_FAIL: cnt_nxt[1] = cnt_r[1] + 16'd1;
              ctcl_pkg::TAG_RPM: begin
                if (mok_rx) rpm_nxt[midx_rx] = cmd.item.byte_3;
              end
              ctcl_pkg::TAG_ENC: begin
                if (mok_rx) enc_nxt[midx_rx] = {cmd.item.byte_4, cmd.item.byte_3};
              end
              ctcl_pkg::TAG_DONE: begin
                cnt_nxt[2] = cnt_r[2] + 16'd1;
                if (cfg.done_event_enable) res.kind = ctcl_pkg::KIND_DONE;
              end
              ctcl_pkg::TAG_LIMIT: begin
                if (cfg.limit_event_enable) begin
                  cnt_nxt[3] = cnt_r[3] + 16'd1;
                  res.kind   = ctcl_pkg::KIND_LIMIT;
                  res.out_0  = cmd.item.byte_2;
                  res.out_1  = cmd.item.byte_3;
                end
              end
              default: ;
            endcase
            if (cmd.item.byte_0 != ctcl_pkg::TAG_DONE) wait_nxt = 1'b0;
          end
        end
        ctcl_pkg::OP_MQ: begin
          res.kind = ctcl_pkg::KIND_MOTOR;
          if (mok_q) begin
            res.out_0 = rpm_r[midx_q];
            res.out_1 = enc_r[midx_q][7:0];
            res.out_2 = enc_r[midx_q][15:8];
          end
        end
        ctcl_pkg::OP_CQ: begin
          res.kind  = ctcl_pkg::KIND_CNT;
          res.out_0 = cnt_r[0][7:0];
          res.out_1 = cnt_r[0][15:8];
          res.out_2 = cnt_r[1][7:0];
          res.out_3 = cnt_r[1][15:8];
          res.out_4 = cnt_r[2][7:0];
          res.out_5 = cnt_r[2][15:8];
          res.out_6 = cnt_r[3][7:0];
          res.out_7 = cnt_r[3][15:8];
        end
        default: ;
      endcase
    end
    res.awaiting_reply = wait_nxt;
  end

  // result register valid
  always_comb begin
    out_valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // control state and tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      used_r      <= '0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ctcl_pkg::MOTOR_COUNT; i++) begin
        rpm_r[i] <= 8'd0;
        enc_r[i] <= 16'd0;
      end
      for (int i = 0; i < 4; i++) cnt_r[i] <= 16'd0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      used_r      <= used_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
      rpm_r       <= rpm_nxt;
      enc_r       <= enc_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // segment storage and result payload
  always_ff @(posedge clk) begin
    if (wr0_en) seg_r[tail_r] <= seg0;
    if (wr1_en) seg_r[tail1] <= seg1;
    if (take) out_data_r <= res;
  end

`include "can_tlv_command_link_top_macros.svh"

  `CTCL_ASSERT_NOW(a_used_bound, 1'b1, used_r <= ctcl_pkg::QCNT_W'(ctcl_pkg::QUEUE_DEPTH))
  `CTCL_ASSERT_NOW(a_tx_sets_wait, out_valid_r && (out_data_r.kind == ctcl_pkg::KIND_TX), out_data_r.awaiting_reply)
  `CTCL_ASSERT_NOW(a_len_only_tx, out_valid_r && (out_data_r.frame_len != 4'd0), out_data_r.kind == ctcl_pkg::KIND_TX)
  `CTCL_ASSERT_NEXT(a_send_pops, take && (cmd.op == ctcl_pkg::OP_SEND) && (res.kind == ctcl_pkg::KIND_TX), wait_r)

endmodule

[hdl/can_tlv_command_link_top.sv]
// top level of the tlv command link: configuration registers and front/back wiring
// Host side of a stop-and-wait CAN command link. One item is accepted per clock while the
// two-entry command queue has room; classification is combinational in front of that queue
// and the back end executes the queued command into the output register, so an item passes
// a command queue entry and then the output register on its way to a result. With no output
// stall the sustained rate is one item per cycle, set by the back end and its output
// register; a stalled result holds the back end and, once the command queue is full, the
// input. Configuration writes are taken at once (cfg_ready is high).
module can_tlv_command_link_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctcl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ctcl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [10:0]         cfg_data
);

  ctcl_pkg::cfg_t cfg_r, cfg_nxt;
  ctcl_pkg::cmd_t f_cmd, q_cmd;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // configuration register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ctcl_pkg::CFG_LINK_EN:  cfg_nxt.link_enable        = cfg_data[0];
        ctcl_pkg::CFG_TX_ID:    cfg_nxt.tx_frame_id        = cfg_data;
        ctcl_pkg::CFG_DONE_EN:  cfg_nxt.done_event_enable  = cfg_data[0];
        ctcl_pkg::CFG_LIMIT_EN: cfg_nxt.limit_event_enable = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ctcl_front u_front (
    .item (in_data),
    .cmd  (f_cmd)
  );

  ctcl_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  ctcl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/can_tlv_command_link_top_tb.sv]
// self-checking testbench for the tlv command link: predicted results versus block output
module can_tlv_command_link_top_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ctcl_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ctcl_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [3:0]          cfg_index = '0;
  logic [10:0]         cfg_data = '0;

  can_tlv_command_link_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic           link_en_q, done_en_q, limit_en_q;
  logic [10:0]    tx_id_q;
  ctcl_pkg::seg_t seg_mem [ctcl_pkg::QUEUE_DEPTH];
  int             seg_head, seg_tail, seg_used;
  logic           wait_q;
  logic [7:0]     rpm_mem [ctcl_pkg::MOTOR_COUNT];
  logic [15:0]    enc_mem [ctcl_pkg::MOTOR_COUNT];
  logic [15:0]    evt_cnt [4];

  ctcl_pkg::in_item_t  pending_items[$];
  ctcl_pkg::out_item_t expected_results[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          tx_seen = 0;
  int          event_seen = 0;

  // queue of register writes, applied only while idle
  logic [3:0]  cfg_idx_q[$];
  logic [10:0] cfg_val_q[$];

  function automatic void apply_cfg(logic [3:0] idx, logic [10:0] val);
    case (idx)
      ctcl_pkg::CFG_LINK_EN:  link_en_q = val[0];
      ctcl_pkg::CFG_TX_ID:    tx_id_q = val;
      ctcl_pkg::CFG_DONE_EN:  done_en_q = val[0];
      ctcl_pkg::CFG_LIMIT_EN: limit_en_q = val[0];
      default: ;
    endcase
  endfunction

  function automatic void push_seg(logic [7:0] tag, logic [3:0] len, logic [1:0] part,
                                   logic [7:0] v [9], int first, int n);
    ctcl_pkg::seg_t s;
    s.tag = tag;
    s.len = len;
    s.part = part;
    for (int i = 0; i < 6; i++) s.data[i] = (i < n) ? v[first + i] : 8'h00;
    seg_mem[seg_tail] = s;
    seg_tail = (seg_tail + 1) % ctcl_pkg::QUEUE_DEPTH;
    seg_used++;
  endfunction

  // computes the link's answer to one item and advances the predicted state
  function automatic ctcl_pkg::out_item_t link_response(ctcl_pkg::in_item_t it);
    ctcl_pkg::out_item_t r;
    logic [7:0] v [9];
    logic [7:0] bytes [8];
    int n, need;
    ctcl_pkg::seg_t s;
    r = '0;
    v = '{it.byte_0, it.byte_1, it.byte_2, it.byte_3, it.byte_4, it.byte_5,
          it.byte_6, it.byte_7, it.byte_8};
    bytes = '{default: 8'h00};
    case (it.req_type)
      ctcl_pkg::REQ_ENQ: begin
        if (it.count <= 9) begin
          need = (it.count < 7) ? 1 : 2;
          if (seg_used + need > ctcl_pkg::QUEUE_DEPTH) begin
            r.queue_full = 1'b1;
          end else if (it.count < 7) begin
            push_seg(it.head_code[7:0], it.count, ctcl_pkg::PART_WHOLE, v, 0, it.count);
          end else begin
            push_seg(it.head_code[7:0], it.count, ctcl_pkg::PART_FIRST, v, 0, 6);
            push_seg(it.head_code[7:0], it.count, ctcl_pkg::PART_SECOND, v, 6,
                     it.count - 6);
          end
        end
      end
      ctcl_pkg::REQ_RX: begin
        if (it.head_code == ctcl_pkg::RX_ID && it.count >= 2 && it.count <= 8 &&
            {4'd0, it.count} - 8'd2 == it.byte_1) begin
          case (it.byte_0)
            ctcl_pkg::TAG_OK:   evt_cnt[0]++;
            ctcl_pkg::TAG_FAIL: evt_cnt[1]++;
            ctcl_pkg::TAG_RPM:
              if (it.byte_2 < ctcl_pkg::MOTOR_COUNT) rpm_mem[it.byte_2] = it.byte_3;
            ctcl_pkg::TAG_ENC:
              if (it.byte_2 < ctcl_pkg::MOTOR_COUNT)
                enc_mem[it.byte_2] = {it.byte_4, it.byte_3};
            ctcl_pkg::TAG_DONE: begin
              evt_cnt[2]++;
              if (done_en_q) r.kind = ctcl_pkg::KIND_DONE;
            end
            ctcl_pkg::TAG_LIMIT: begin
              if (limit_en_q) begin
                evt_cnt[3]++;
                r.kind = ctcl_pkg::KIND_LIMIT;
                bytes[0] = it.byte_2;
                bytes[1] = it.byte_3;
              end
            end
            default: ;
          endcase
          if (it.byte_0 != ctcl_pkg::TAG_DONE) wait_q = 1'b0;
        end
      end
      ctcl_pkg::REQ_SEND: begin
        if (link_en_q && seg_used != 0 && !wait_q) begin
          s = seg_mem[seg_head];
          if (s.part == ctcl_pkg::PART_FIRST) n = 6;
          else if (s.part == ctcl_pkg::PART_SECOND) n = s.len - 6;
          else n = s.len;
          r.kind = ctcl_pkg::KIND_TX;
          r.frame_len = n + 2;
          bytes[0] = s.tag;
          bytes[1] = {4'd0, s.len};
          for (int i = 0; i < 6; i++) bytes[2 + i] = (i < n) ? s.data[i] : 8'h00;
          seg_head = (seg_head + 1) % ctcl_pkg::QUEUE_DEPTH;
          seg_used--;
          wait_q = 1'b1;
        end
      end
      ctcl_pkg::REQ_MQ: begin
        r.kind = ctcl_pkg::KIND_MOTOR;
        if (it.byte_0 < ctcl_pkg::MOTOR_COUNT) begin
          bytes[0] = rpm_mem[it.byte_0];
          bytes[1] = enc_mem[it.byte_0][7:0];
          bytes[2] = enc_mem[it.byte_0][15:8];
        end
      end
      ctcl_pkg::REQ_CQ: begin
        r.kind = ctcl_pkg::KIND_CNT;
        for (int i = 0; i < 4; i++) begin
          bytes[2 * i] = evt_cnt[i][7:0];
          bytes[2 * i + 1] = evt_cnt[i][15:8];
        end
      end
      default: ;
    endcase
    r.out_0 = bytes[0]; r.out_1 = bytes[1]; r.out_2 = bytes[2]; r.out_3 = bytes[3];
    r.out_4 = bytes[4]; r.out_5 = bytes[5]; r.out_6 = bytes[6]; r.out_7 = bytes[7];
    r.awaiting_reply = wait_q;
    return r;
  endfunction

  // item builders
  function automatic ctcl_pkg::in_item_t rand_item();
    ctcl_pkg::in_item_t it;
    it = ctcl_pkg::in_item_t'({$urandom, $urandom, $urandom});
    it.req_type = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic ctcl_pkg::in_item_t rx_item(logic [7:0] tag, logic [7:0] a,
                                                 logic [7:0] b, logic [7:0] c);
    ctcl_pkg::in_item_t it;
    int sz;
    it = rand_item();
    sz = $urandom_range(2, 8);
    it.req_type = ctcl_pkg::REQ_RX;
    it.head_code = ctcl_pkg::RX_ID;
    it.count = sz;
    it.byte_0 = tag;
    it.byte_1 = sz - 2;
    it.byte_2 = a; it.byte_3 = b; it.byte_4 = c;
    return it;
  endfunction

  function automatic ctcl_pkg::in_item_t enq_item(int len);
    ctcl_pkg::in_item_t it;
    it = rand_item();
    it.req_type = ctcl_pkg::REQ_ENQ;
    it.count = len;
    return it;
  endfunction

  function automatic ctcl_pkg::in_item_t op_item(logic [2:0] req, logic [7:0] b0);
    ctcl_pkg::in_item_t it;
    it = rand_item();
    it.req_type = req;
    it.byte_0 = b0;
    return it;
  endfunction

  // sender: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(link_response(in_data));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
          pending_items.delete(0);
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern with stall-free stretches
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 9) < 6) || (stall_phase % 7 == 3);
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    ctcl_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        fail_count++;
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        if (e.kind == ctcl_pkg::KIND_TX) tx_seen++;
        if (e.kind == ctcl_pkg::KIND_DONE || e.kind == ctcl_pkg::KIND_LIMIT) event_seen++;
        if (out_data.kind !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, out_data.kind); fail_count++;
        end
        if (out_data.frame_len !== e.frame_len) begin
          $error("frame_len expected %0d actual %0d", e.frame_len, out_data.frame_len);
          fail_count++;
        end
        if (out_data.out_0 !== e.out_0) begin
          $error("out_0 expected %h actual %h", e.out_0, out_data.out_0); fail_count++;
        end
        if (out_data.out_1 !== e.out_1) begin
          $error("out_1 expected %h actual %h", e.out_1, out_data.out_1); fail_count++;
        end
        if (out_data.out_2 !== e.out_2) begin
          $error("out_2 expected %h actual %h", e.out_2, out_data.out_2); fail_count++;
        end
        if (out_data.out_3 !== e.out_3) begin
          $error("out_3 expected %h actual %h", e.out_3, out_data.out_3); fail_count++;
        end
        if (out_data.out_4 !== e.out_4) begin
          $error("out_4 expected %h actual %h", e.out_4, out_data.out_4); fail_count++;
        end
        if (out_data.out_5 !== e.out_5) begin
          $error("out_5 expected %h actual %h", e.out_5, out_data.out_5); fail_count++;
        end
        if (out_data.out_6 !== e.out_6) begin
          $error("out_6 expected %h actual %h", e.out_6, out_data.out_6); fail_count++;
        end
        if (out_data.out_7 !== e.out_7) begin
          $error("out_7 expected %h actual %h", e.out_7, out_data.out_7); fail_count++;
        end
        if (out_data.queue_full !== e.queue_full) begin
          $error("queue_full expected %b actual %b", e.queue_full, out_data.queue_full);
          fail_count++;
        end
        if (out_data.awaiting_reply !== e.awaiting_reply) begin
          $error("awaiting_reply expected %b actual %b", e.awaiting_reply,
                 out_data.awaiting_reply);
          fail_count++;
        end
      end
    end
  end

  // register writer, used only while the link is idle
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (!cfg_valid || cfg_ready) begin
        if (cfg_idx_q.size() != 0) begin
          cfg_valid <= 1'b1;
          cfg_index <= cfg_idx_q[0];
          cfg_data <= cfg_val_q[0];
          cfg_idx_q.delete(0);
          cfg_val_q.delete(0);
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [3:0] idx, logic [10:0] val);
    cfg_idx_q.push_back(idx);
    cfg_val_q.push_back(val);
    while (cfg_idx_q.size() != 0 || cfg_valid) @(posedge clk);
  endtask

  task automatic set_phase(logic le, logic [10:0] id, logic de, logic lm);
    wait_idle();
    write_cfg(ctcl_pkg::CFG_LINK_EN, {10'd0, le});
    write_cfg(ctcl_pkg::CFG_TX_ID, id);
    write_cfg(ctcl_pkg::CFG_DONE_EN, {10'd0, de});
    write_cfg(ctcl_pkg::CFG_LIMIT_EN, {10'd0, lm});
  endtask

  // one random item, mostly well-formed traffic
  function automatic ctcl_pkg::in_item_t traffic_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return enq_item($urandom_range(0, 9));
    if (pick < 55) return op_item(ctcl_pkg::REQ_SEND, 8'($urandom));
    if (pick < 75) return rx_item(8'($urandom_range(8'h3e, 8'h47)),
                                  8'($urandom_range(0, 5)), 8'($urandom), 8'($urandom));
    if (pick < 82) return op_item(ctcl_pkg::REQ_MQ, 8'($urandom_range(0, 6)));
    if (pick < 87) return op_item(ctcl_pkg::REQ_CQ, 8'($urandom));
    return rand_item();
  endfunction

  initial begin
    ctcl_pkg::in_item_t it;
    link_en_q = 0; done_en_q = 0; limit_en_q = 0; tx_id_q = '0;
    seg_head = 0; seg_tail = 0; seg_used = 0; wait_q = 0;
    for (int i = 0; i < ctcl_pkg::MOTOR_COUNT; i++) begin
      rpm_mem[i] = '0;
      enc_mem[i] = '0;
    end
    for (int i = 0; i < 4; i++) evt_cnt[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: send with link disabled, then extremes and special cases
    pending_items.push_back(enq_item(0));
    pending_items.push_back(op_item(ctcl_pkg::REQ_SEND, 8'h00));
    pending_items.push_back(op_item(3'd7, 8'hff));
    pending_items.push_back(op_item(3'd5, 8'h00));
    set_phase(1'b1, 11'h7ff, 1'b1, 1'b1);
    pending_items.push_back(op_item(ctcl_pkg::REQ_SEND, 8'h00));
    for (int l = 6; l <= 10; l++) pending_items.push_back(enq_item((l == 10) ? 15 : l));
    pending_items.push_back(op_item(ctcl_pkg::REQ_SEND, 8'h00));
    pending_items.push_back(rx_item(ctcl_pkg::TAG_DONE, 8'h0, 8'h0, 8'h0));
    pending_items.push_back(op_item(ctcl_pkg::REQ_SEND, 8'h00));
    pending_items.push_back(rx_item(ctcl_pkg::TAG_LIMIT, 8'hff, 8'h01, 8'h0));
    pending_items.push_back(rx_item(ctcl_pkg::TAG_RPM, 8'h03, 8'hff, 8'h0));
    pending_items.push_back(rx_item(ctcl_pkg::TAG_ENC, 8'h03, 8'hff, 8'hff));
    pending_items.push_back(rx_item(ctcl_pkg::TAG_RPM, 8'h04, 8'h11, 8'h0));
    pending_items.push_back(rx_item(ctcl_pkg::TAG_OK, 0, 0, 0));
    pending_items.push_back(rx_item(ctcl_pkg::TAG_FAIL, 0, 0, 0));
    pending_items.push_back(rx_item(8'hff, 0, 0, 0));
    it = rx_item(ctcl_pkg::TAG_OK, 0, 0, 0); it.head_code = 11'h445;
    pending_items.push_back(it);
    it = rx_item(ctcl_pkg::TAG_OK, 0, 0, 0); it.count = 9; it.byte_1 = 7;
    pending_items.push_back(it);
    it = rx_item(ctcl_pkg::TAG_OK, 0, 0, 0); it.byte_1 = 8'hff;
    pending_items.push_back(it);
    pending_items.push_back(op_item(ctcl_pkg::REQ_MQ, 8'h03));
    pending_items.push_back(op_item(ctcl_pkg::REQ_MQ, 8'hff));
    pending_items.push_back(op_item(ctcl_pkg::REQ_CQ, 8'h00));
    // fill the queue to exercise rejection
    for (int i = 0; i < 10; i++) pending_items.push_back(enq_item(9));

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      set_phase((ph != 2), 11'($urandom), ph[0], ph[1] | (ph == 4));
      for (int i = 0; i < 280; i++) pending_items.push_back(traffic_item());
    end
    wait_idle();
    repeat (10) @(posedge clk);

    $display("covered %0d items, %0d results, %0d frames sent, %0d events",
             items_sent, results_seen, tx_seen, event_seen);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/ctcl_pkg.sv
hdl/ctcl_front.sv
hdl/ctcl_cmdq.sv
hdl/ctcl_back.sv
hdl/can_tlv_command_link_top.sv
tb/can_tlv_command_link_top_tb.sv
